// ----- hw/rtl/ema_pkg.sv -----
// ema_pkg: shared types and constants for the ema weight update block
// no dependencies
package ema_pkg;

    localparam int VALUE_WIDTH_DEF     = 32;
    localparam int DECAY_FRAC_BITS_DEF = 16;
    localparam int TERMS               = 20;
    localparam int QQ_MAX              = 32;

    localparam logic [31:0] Q31_ONE = 32'h8000_0000;

    localparam logic [15:0] MAX_DECAY_RST   = 16'd64880;
    localparam logic [15:0] DECAY_RAMP_RST  = 16'd2000;
    localparam logic [31:0] INIT_UPD_RST    = 32'd0;

    localparam logic [1:0] REG_MAX_DECAY  = 2'd0;
    localparam logic [1:0] REG_DECAY_RAMP = 2'd1;
    localparam logic [1:0] REG_INIT_UPD   = 2'd2;
    localparam logic [1:0] REG_ENABLED    = 2'd3;

    typedef struct packed {
        logic                       new_pass;
        logic [VALUE_WIDTH_DEF-1:0] current_value;
        logic [VALUE_WIDTH_DEF-1:0] average_value;
    } t_in_item;

    typedef struct packed {
        logic [VALUE_WIDTH_DEF-1:0] new_average;
        logic [15:0]                decay_used;
    } t_out_item;

endpackage

// ----- hw/rtl/ema_decay_unit.sv -----
// ema_decay_unit: sequential decay recompute (divide, taylor exp, power of e^-1, scale)
// depends on ema_pkg
module ema_decay_unit
    import ema_pkg::*;
#(
    parameter int DECAY_FRAC_BITS = DECAY_FRAC_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [31:0]                i_count,
    input  logic [15:0]                i_ramp,
    input  logic [15:0]                i_max_decay,
    output logic                       o_busy,
    output logic                       o_done,
    output logic [DECAY_FRAC_BITS-1:0] o_decay
);
    localparam int SHIFT = 47 - DECAY_FRAC_BITS;

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_DIV  = 8'b0000_0010,
        S_FDIV = 8'b0000_0100,
        S_EMUL = 8'b0000_1000,
        S_EDIV = 8'b0001_0000,
        S_POW  = 8'b0010_0000,
        S_SCL  = 8'b0100_0000,
        S_DONE = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;

    // restoring divider shared by count/ramp, (r<<31)/ramp and the taylor term divides by k
    logic [62:0] r_dvd;
    logic [31:0] r_rem;
    logic [15:0] r_den;
    logic [5:0]  r_bit;
    logic [31:0] r_quo;
    logic [31:0] r_q;
    logic [31:0] r_f;
    logic [31:0] r_term;
    logic [32:0] r_sum;     // signed
    logic [4:0]  r_k;
    logic        r_pass1;   // first pass computes e^-1
    logic [31:0] r_e1;
    logic [31:0] r_e;
    logic [63:0] r_prod;
    logic [5:0]  r_pow;

    logic [32:0] w_trial;
    logic [31:0] w_rem_next;
    logic [63:0] w_mul;
    logic [63:0] w_scl;

    function automatic logic [31:0] w_clamp_next(logic [32:0] s, logic odd, logic [31:0] t);
        logic [32:0] v;
        v = odd ? s - {1'b0, t} : s + {1'b0, t};
        if (v[32]) return 32'd0;
        if (v[31:0] > Q31_ONE) return Q31_ONE;
        return v[31:0];
    endfunction

    assign w_trial    = {r_rem, r_dvd[62]} - {17'd0, r_den};
    assign w_rem_next = w_trial[32] ? {r_rem[30:0], r_dvd[62]} : w_trial[31:0];

    assign w_mul = r_term * (r_pass1 ? Q31_ONE : r_f);
    assign w_scl = {32'd0, Q31_ONE - r_e} * {48'd0, i_max_decay};

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (i_start) n_state = S_DIV;
            S_DIV:  if (r_bit == 6'd0) n_state = S_FDIV;
            S_FDIV: if (r_bit == 6'd0) n_state = S_EMUL;
            S_EMUL: n_state = S_EDIV;
            S_EDIV: if (r_bit == 6'd0 && r_k == 5'(TERMS) && !r_pass1) n_state = S_POW;
                    else if (r_bit == 6'd0) n_state = S_EMUL;
            S_POW:  if (r_pow == 6'd0 || r_q >= 32'(QQ_MAX)) n_state = S_SCL;
            S_SCL:  n_state = S_DONE;
            S_DONE: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
            case (r_state)
                S_IDLE: if (i_start) begin
                    r_den  <= (i_ramp == 16'd0) ? 16'd1 : i_ramp;
                    r_dvd  <= {i_count, 31'd0};
                    r_rem  <= '0;
                    r_quo  <= '0;
                    r_bit  <= 6'd31;
                end
                S_DIV: begin
                    r_rem <= w_rem_next;
                    r_quo <= {r_quo[30:0], ~w_trial[32]};
                    r_dvd <= {r_dvd[61:0], 1'b0};
                    r_bit <= r_bit - 6'd1;
                    if (r_bit == 6'd0) begin
                        r_q   <= {r_quo[30:0], ~w_trial[32]};
                        // remainder < ramp < 2^16, 48 steps then shift in r<<31
                        r_dvd <= {1'b0, w_rem_next[15:0], 46'd0};
                        r_rem <= '0;
                        r_quo <= '0;
                        r_bit <= 6'd47;
                    end
                end
                S_FDIV: begin
                    r_rem <= w_rem_next;
                    r_quo <= {r_quo[30:0], ~w_trial[32]};
                    r_dvd <= {r_dvd[61:0], 1'b0};
                    r_bit <= r_bit - 6'd1;
                    if (r_bit == 6'd0) begin
                        r_f     <= {r_quo[30:0], ~w_trial[32]};
                        r_term  <= Q31_ONE;
                        r_sum   <= {1'b0, Q31_ONE};
                        r_k     <= 5'd1;
                        r_pass1 <= 1'b1;
                    end
                end
                S_EMUL: begin
                    // term*f>>31 fits in 32 bits since f <= 1.0
                    r_dvd <= {w_mul[62:31], 31'd0};
                    r_rem <= '0;
                    r_quo <= '0;
                    r_den <= {11'd0, r_k};
                    r_bit <= 6'd31;
                end
                S_EDIV: begin
                    r_rem <= w_rem_next;
                    r_quo <= {r_quo[30:0], ~w_trial[32]};
                    r_dvd <= {r_dvd[61:0], 1'b0};
                    r_bit <= r_bit - 6'd1;
                    if (r_bit == 6'd0) begin
                        r_term <= {r_quo[30:0], ~w_trial[32]};
                        if (r_k[0])
                            r_sum <= r_sum - {1'b0, r_quo[30:0], ~w_trial[32]};
                        else
                            r_sum <= r_sum + {1'b0, r_quo[30:0], ~w_trial[32]};
                        r_k <= r_k + 5'd1;
                    end
                end
                S_POW: begin
                    if (r_pow != 6'd0 && r_q < 32'(QQ_MAX)) begin
                        r_e   <= 32'(({32'd0, r_e} * {32'd0, r_e1}) >> 31);
                        r_pow <= r_pow - 6'd1;
                    end
                    if (r_q >= 32'(QQ_MAX)) r_e <= '0;
                end
                S_SCL: r_prod <= w_scl;
                default: ;
            endcase
            // end of a taylor sum: first pass gives e^-1, second gives exp(-f)
            if (r_state == S_EDIV && r_bit == 6'd0 && r_k == 5'(TERMS)) begin
                if (r_pass1) begin
                    r_e1    <= w_clamp_next(r_sum, r_k[0], {r_quo[30:0], ~w_trial[32]});
                    r_pass1 <= 1'b0;
                    r_term  <= Q31_ONE;
                    r_sum   <= {1'b0, Q31_ONE};
                    r_k     <= 5'd1;
                end else begin
                    r_e   <= w_clamp_next(r_sum, r_k[0], {r_quo[30:0], ~w_trial[32]});
                    r_pow <= r_q[5:0];
                end
            end
        end
    end

    assign o_busy  = (r_state != S_IDLE);
    assign o_done  = (r_state == S_DONE);
    // rounded scale, valid while o_done is high
    assign o_decay = DECAY_FRAC_BITS'((r_prod + (64'd1 << (SHIFT - 1))) >> SHIFT);

    a_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n) $onehot(r_state))
        else $error("decay unit state not one-hot");
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> r_state == S_IDLE) else $error("done not followed by idle");
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_start) |=> o_busy) else $error("start ignored");
endmodule

// ----- hw/rtl/ema_front.sv -----
// ema_front: input queue between accept side and datapath
// depends on ema_pkg
module ema_front
    import ema_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_push,
    input  t_in_item i_item,
    output logic     o_full,
    input  logic     i_take,
    output logic     o_avail,
    output t_in_item o_item
);
    t_in_item r_q [2];
    logic     r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_avail = (r_cnt != 2'd0);
    assign o_item  = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push && !o_full) r_q[r_wp] <= i_item;
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= 2'd0;
        end else begin
            if (i_push && !o_full) r_wp <= ~r_wp;
            if (i_take && o_avail) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(i_push && !o_full) - 2'(i_take && o_avail);
        end
    end

    a_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n) r_cnt != 2'd3)
        else $error("front queue overflow");
endmodule

// ----- hw/rtl/ema_weight_update_ramped_decay_top.sv -----
// Exponential moving average weight update with a decay that ramps with the update count.
// Plain elements stream through a two-entry input queue and a two-stage datapath at one
// per cycle while the output is not stalled. An element that starts a new pass while the
// block is enabled waits at the queue head while the serial decay unit runs: 32 and 48
// divide steps, two 20-term series, multiplies by e^-1, then a scale and hand over.
// Configuration must be written only while nothing is in flight;
// the block itself does not enforce it.
// depends on ema_pkg, ema_front, ema_decay_unit
module ema_weight_update_ramped_decay_top
    import ema_pkg::*;
#(
    parameter int DECAY_FRAC_BITS = DECAY_FRAC_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  t_in_item    i_in,
    output logic        empty,
    input  logic        pop,
    output t_out_item   o_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    localparam int VALUE_WIDTH = VALUE_WIDTH_DEF;
    localparam logic [VALUE_WIDTH-1:0] SBIT = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
    localparam logic [DECAY_FRAC_BITS:0] ONE = {1'b1, {DECAY_FRAC_BITS{1'b0}}};

    logic [15:0] r_max_decay, r_ramp;
    logic [31:0] r_init, r_count;
    logic        r_enabled;
    logic [DECAY_FRAC_BITS-1:0] r_decay;

    logic w_wr;
    logic [1:0] w_idx;
    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    assign w_idx  = paddr[3:2];

    always_comb begin
        case (w_idx)
            REG_MAX_DECAY:  prdata = {16'd0, r_max_decay};
            REG_DECAY_RAMP: prdata = {16'd0, r_ramp};
            REG_INIT_UPD:   prdata = r_init;
            REG_ENABLED:    prdata = {31'd0, r_enabled};
            default:        prdata = '0;
        endcase
    end

    logic     w_avail, w_take;
    t_in_item w_item;
    ema_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(push), .i_item(i_in), .o_full(full),
        .i_take(w_take), .o_avail(w_avail), .o_item(w_item)
    );

    logic w_start, w_busy, w_done;
    logic [DECAY_FRAC_BITS-1:0] w_new_decay;
    logic r_waiting;
    logic r_ready;      // decay for the pass element at the head is already in r_decay
    logic [31:0] w_count_inc;
    assign w_count_inc = (r_count == 32'hFFFF_FFFF) ? r_count : r_count + 32'd1;

    ema_decay_unit #(.DECAY_FRAC_BITS(DECAY_FRAC_BITS)) u_decay (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_start), .i_count(w_count_inc),
        .i_ramp(r_ramp), .i_max_decay(r_max_decay), .o_busy(w_busy), .o_done(w_done),
        .o_decay(w_new_decay)
    );

    // stage 1 registers
    logic r_s1_v, r_s1_en;
    logic [VALUE_WIDTH-1:0] r_lo, r_span, r_avg;
    logic [DECAY_FRAC_BITS:0] r_wt;
    logic [DECAY_FRAC_BITS-1:0] r_s1_decay;
    // output register
    logic r_out_v;
    t_out_item r_out;

    logic w_s1_free, w_go, w_needs, w_fresh;
    assign w_s1_free = !r_s1_v || !r_out_v || pop;
    assign w_needs   = w_item.new_pass && r_enabled;
    assign w_fresh   = r_waiting && w_done;
    assign w_start   = w_avail && w_needs && !r_waiting && !r_ready && !w_busy && w_s1_free;
    assign w_go      = w_avail && w_s1_free && (!w_needs || r_ready || w_fresh);
    assign w_take    = w_go;

    logic [DECAY_FRAC_BITS-1:0] w_d;
    assign w_d = w_fresh ? w_new_decay : r_decay;

    logic [VALUE_WIDTH-1:0] w_cur, w_avg;
    assign w_cur = VALUE_WIDTH'(w_item.current_value) ^ SBIT;
    assign w_avg = VALUE_WIDTH'(w_item.average_value) ^ SBIT;

    logic [VALUE_WIDTH+DECAY_FRAC_BITS:0] w_hi_p, w_lo_p, w_off;
    assign w_hi_p = (VALUE_WIDTH+DECAY_FRAC_BITS+1)'(r_span >> DECAY_FRAC_BITS) * r_wt;
    assign w_lo_p = (VALUE_WIDTH+DECAY_FRAC_BITS+1)'(r_span[DECAY_FRAC_BITS-1:0]) * r_wt
                  + (VALUE_WIDTH+DECAY_FRAC_BITS+1)'(ONE >> 1);
    assign w_off  = w_hi_p + (w_lo_p >> DECAY_FRAC_BITS);

    logic [VALUE_WIDTH-1:0] w_res;
    assign w_res = (r_lo + w_off[VALUE_WIDTH-1:0]) ^ SBIT;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_decay <= MAX_DECAY_RST;
            r_ramp      <= DECAY_RAMP_RST;
            r_init      <= INIT_UPD_RST;
            r_enabled   <= 1'b1;
            r_count     <= INIT_UPD_RST;
            r_decay     <= '0;
            r_waiting   <= 1'b0;
            r_ready     <= 1'b0;
            r_s1_v      <= 1'b0;
            r_out_v     <= 1'b0;
        end else begin
            if (w_wr) begin
                case (w_idx)
                    REG_MAX_DECAY:  r_max_decay <= pwdata[15:0];
                    REG_DECAY_RAMP: r_ramp      <= pwdata[15:0];
                    REG_INIT_UPD: begin
                        r_init  <= pwdata;
                        r_count <= pwdata;
                    end
                    REG_ENABLED:    r_enabled   <= pwdata[0];
                    default: ;
                endcase
            end
            if (w_start) r_waiting <= 1'b1;
            if (w_fresh) begin
                r_waiting <= 1'b0;
                r_decay   <= w_new_decay;
                r_count   <= w_count_inc;
            end
            // hold the new decay when the datapath cannot take the pass element yet
            if (w_fresh && !w_go) r_ready <= 1'b1;
            else if (w_go) r_ready <= 1'b0;
            if (w_s1_free) r_s1_v <= w_go;
            if (r_s1_v && (!r_out_v || pop)) r_out_v <= 1'b1;
            else if (pop) r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_go) begin
            r_s1_en    <= r_enabled;
            r_avg      <= VALUE_WIDTH'(w_item.average_value);
            r_s1_decay <= w_d;
            if (w_cur >= w_avg) begin
                r_lo   <= w_avg;
                r_span <= w_cur - w_avg;
                r_wt   <= ONE - {1'b0, w_d};
            end else begin
                r_lo   <= w_cur;
                r_span <= w_avg - w_cur;
                r_wt   <= {1'b0, w_d};
            end
        end
        if (r_s1_v && (!r_out_v || pop)) begin
            r_out.new_average <= r_s1_en ? w_res : r_avg;
            r_out.decay_used  <= r_s1_en ?
                16'(({16'd0, r_s1_decay} << 16) >> DECAY_FRAC_BITS) : 16'd0;
        end
    end

    assign empty = !r_out_v;
    assign o_out = r_out;

    a_wait_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_waiting |-> (w_busy || w_done)) else $error("waiting without decay unit");
    a_no_go_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_go && w_needs) |-> (w_done || r_ready)) else $error("pass item went before decay");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && !pop) |=> r_out_v) else $error("result dropped");
endmodule
